/* design/printable_vigenere_cipher_defines.svh */
// Assertion helpers for the printable Vigenere cipher.
`ifndef PRINTABLE_VIGENERE_CIPHER_DEFINES_SVH
`define PRINTABLE_VIGENERE_CIPHER_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, checked outside reset.
`define PVC_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("pvc check failed");

// Next-cycle implication, checked outside reset.
`define PVC_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("pvc check failed");

`else

`define PVC_ASSERT_NOW(label, clk, rst, cond, prop)
`define PVC_ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

/* design/pvc_pkg.sv */
package pvc_pkg;

   localparam int KEY_DEPTH = 256;
   localparam int KEY_AW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
   localparam int LEN_W     = $clog2(KEY_DEPTH + 1);

   localparam logic [7:0] CODE_LOW  = 8'd32;
   localparam logic [7:0] CODE_HIGH = 8'd126;
   localparam logic [7:0] CODE_SPAN = 8'd95;
   localparam logic [7:0] ESC_BYTE  = 8'd27;
   localparam logic [7:0] ESC_END   = 8'h6d;   // 'm'

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_TEXT   = 2'd2,
      OP_REWIND = 2'd3
   } opcode_type;

   // Key memory access issued by the control stage.
   typedef struct packed {
      logic              we;
      logic [KEY_AW-1:0] waddr;
      logic [6:0]        wdata;
      logic              re;
      logic [KEY_AW-1:0] raddr;
   } key_ram_req_type;

   // Text byte waiting for its key byte.
   typedef struct packed {
      logic       valid;
      logic       pass;
      logic       decrypt;
      logic [7:0] data;
   } text_item_type;

endpackage

/* design/pvc_key_ram.sv */
module pvc_key_ram (
   input  logic                   clock,
   input  pvc_pkg::key_ram_req_type ram_req,
   output logic [6:0]             rd_data
);

   logic [6:0] key_mem_ff [pvc_pkg::KEY_DEPTH];
   logic [6:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         key_mem_ff[ram_req.waddr] <= ram_req.wdata;
      end
   end

   // Hold read data when no read is issued so a stalled item keeps its key.
   always_ff @(posedge clock) begin
      if (ram_req.re) begin
         rd_data_ff <= key_mem_ff[ram_req.raddr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/pvc_key_ctrl.sv */
module pvc_key_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,
   input  logic [2:0]                req_tuser,
   input  logic                      shift_adv,
   output pvc_pkg::key_ram_req_type  ram_req,
   output pvc_pkg::text_item_type    item
);

   logic [pvc_pkg::LEN_W-1:0]  key_len_ff, key_len_in;
   logic [pvc_pkg::KEY_AW-1:0] key_pos_ff, key_pos_in;
   logic                       in_esc_ff, in_esc_in;
   pvc_pkg::text_item_type     item_ff, item_in;

   pvc_pkg::opcode_type        opcode;
   logic [7:0]                 data_byte;
   logic                       accept;
   logic                       printable;
   logic [pvc_pkg::KEY_AW-1:0] pos_eff;
   logic [pvc_pkg::LEN_W-1:0]  pos_next;

   assign opcode    = pvc_pkg::opcode_type'(req_tuser[1:0]);
   assign data_byte = req_tdata;
   assign req_tready = !item_ff.valid || shift_adv;
   assign accept    = req_tvalid && req_tready;
   assign printable = (data_byte >= pvc_pkg::CODE_LOW) && (data_byte <= pvc_pkg::CODE_HIGH);

   always_comb begin
      if (pvc_pkg::LEN_W'(key_pos_ff) >= key_len_ff) begin
         pos_eff = '0;
      end else begin
         pos_eff = key_pos_ff;
      end
      pos_next = pvc_pkg::LEN_W'(pos_eff) + pvc_pkg::LEN_W'(1);
   end

   always_comb begin
      key_len_in    = key_len_ff;
      key_pos_in    = key_pos_ff;
      in_esc_in     = in_esc_ff;
      item_in       = item_ff;
      ram_req.we    = 1'b0;
      ram_req.waddr = pvc_pkg::KEY_AW'(key_len_ff);
      ram_req.wdata = data_byte[6:0];
      ram_req.re    = 1'b0;
      ram_req.raddr = pos_eff;

      // Drop the held item once the output side takes it.
      if (shift_adv) begin
         item_in.valid = 1'b0;
      end

      if (accept) begin
         item_in.valid   = 1'b0;
         item_in.pass    = 1'b0;
         item_in.decrypt = req_tuser[2];
         item_in.data    = data_byte;
         case (opcode)
            pvc_pkg::OP_CLEAR: begin
               key_len_in = '0;
               key_pos_in = '0;
               in_esc_in  = 1'b0;
            end
            pvc_pkg::OP_APPEND: begin
               if (in_esc_ff) begin
                  if (data_byte == pvc_pkg::ESC_END) begin
                     in_esc_in = 1'b0;
                  end
               end else if (data_byte == pvc_pkg::ESC_BYTE) begin
                  in_esc_in = 1'b1;
               end else if (printable &&
                            (key_len_ff < pvc_pkg::LEN_W'(pvc_pkg::KEY_DEPTH))) begin
                  ram_req.we = 1'b1;
                  key_len_in = key_len_ff + pvc_pkg::LEN_W'(1);
               end
            end
            pvc_pkg::OP_TEXT: begin
               if (key_len_ff == '0) begin
                  item_in.valid = 1'b1;
                  item_in.pass  = 1'b1;
               end else if (printable) begin
                  item_in.valid = 1'b1;
                  ram_req.re    = 1'b1;
                  if (pos_next >= key_len_ff) begin
                     key_pos_in = '0;
                  end else begin
                     key_pos_in = pvc_pkg::KEY_AW'(pos_next);
                  end
               end
            end
            pvc_pkg::OP_REWIND: begin
               key_pos_in = '0;
            end
            default: begin
               key_pos_in = key_pos_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_len_ff    <= '0;
         key_pos_ff    <= '0;
         in_esc_ff     <= 1'b0;
         item_ff.valid <= 1'b0;
      end else begin
         key_len_ff    <= key_len_in;
         key_pos_ff    <= key_pos_in;
         in_esc_ff     <= in_esc_in;
         item_ff.valid <= item_in.valid;
      end
      item_ff.pass    <= item_in.pass;
      item_ff.decrypt <= item_in.decrypt;
      item_ff.data    <= item_in.data;
   end

   assign item = item_ff;

endmodule

/* design/pvc_shift.sv */
module pvc_shift (
   input  logic                   clock,
   input  logic                   reset,
   input  pvc_pkg::text_item_type item,
   input  logic [6:0]             key_byte,
   output logic                   shift_adv,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,
   output logic                   rsp_tuser
);

   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_pass_ff, out_pass_in;

   logic [6:0] text_ofs;
   logic [6:0] key_ofs;
   logic [7:0] sum;
   logic [7:0] shifted;

   assign shift_adv = item.valid && (!out_valid_ff || rsp_tready);

   // Offsets into the printable range, both 0..94.
   assign text_ofs = item.data[6:0] - pvc_pkg::CODE_LOW[6:0];
   assign key_ofs  = key_byte - pvc_pkg::CODE_LOW[6:0];

   always_comb begin
      if (item.decrypt) begin
         sum = {1'b0, text_ofs} - {1'b0, key_ofs};
         if (text_ofs < key_ofs) begin
            sum = sum + pvc_pkg::CODE_SPAN;
         end
      end else begin
         sum = {1'b0, text_ofs} + {1'b0, key_ofs};
         if (sum >= pvc_pkg::CODE_SPAN) begin
            sum = sum - pvc_pkg::CODE_SPAN;
         end
      end
      shifted = sum + pvc_pkg::CODE_LOW;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_pass_in  = out_pass_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (shift_adv) begin
         out_valid_in = 1'b1;
         out_pass_in  = item.pass;
         out_byte_in  = item.pass ? item.data : shifted;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_pass_ff <= out_pass_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = out_pass_ff;

endmodule

/* design/printable_vigenere_cipher.sv */
// Channel    Direction  tdata (low bit up)   tuser (low bit up)
// req_       in         data_byte[7:0]       opcode[1:0], decrypt[2]
// rsp_       out        out_byte[7:0]        passed_through[0]
//
// One request per cycle, sustained while the response side accepts. A text byte's result is
// registered first by the key memory read, then in the output register.
// Reset empties the key at once; the key memory needs no clearing pass.
// A stalled response holds the output register, then the key-read stage,
// and then req_tready drops.
`include "printable_vigenere_cipher_defines.svh"

module printable_vigenere_cipher (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // data_byte[7:0]
   input  logic [2:0] req_tuser,   // opcode[1:0], decrypt[2]
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte[7:0]
   output logic       rsp_tuser    // passed_through[0]
);

   pvc_pkg::key_ram_req_type ram_req;
   pvc_pkg::text_item_type   item;
   logic [6:0]               key_byte;
   logic                     shift_adv;

   pvc_key_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .shift_adv  (shift_adv),
      .ram_req    (ram_req),
      .item       (item)
   );

   pvc_key_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (key_byte)
   );

   pvc_shift u_shift (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .key_byte   (key_byte),
      .shift_adv  (shift_adv),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // A key write and a key read never share a cycle.
   `PVC_ASSERT_NOW(a_no_rw_overlap, clock, reset, ram_req.we, !ram_req.re)
   // A stalled text item stays in the key-read stage.
   `PVC_ASSERT_NEXT(a_item_held, clock, reset, item.valid && !shift_adv, item.valid)
   // An empty key-read stage always takes a request.
   `PVC_ASSERT_NOW(a_ready_when_empty, clock, reset, !item.valid, req_tready)

endmodule

/* test/printable_vigenere_cipher_tb.sv */
`timescale 1ns / 100ps

module printable_vigenere_cipher_tb;

   localparam int SCRIPT_LEN  = 25;
   localparam int RANDOM_LEN  = 1700;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic [7:0] out_byte;
      logic       passed;
   } cipher_out_type;

   typedef struct packed {
      pvc_pkg::opcode_type op;
      logic [7:0]          data;
      logic                dec;
      logic                typed;
      logic [7:0]          t_byte;
      logic                t_pass;
   } script_row_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic [2:0] req_tuser  = 3'b000;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tuser;

   // Cipher state as seen by the predictor
   logic [6:0]     key_mem [pvc_pkg::KEY_DEPTH];
   int             key_len  = 0;
   int             key_pos  = 0;
   bit             esc_open = 1'b0;
   cipher_out_type cipher_q [$];

   // Typed expectation for the request currently on the bus
   bit          cur_typed  = 1'b0;
   logic [7:0]  cur_t_byte = 8'h00;
   logic        cur_t_pass = 1'b0;

   bit          idle_on  = 1'b1;
   int          sent     = 0;
   int          errors   = 0;
   int          cycles   = 0;

   script_row_type script [SCRIPT_LEN] = '{
      '{pvc_pkg::OP_TEXT,   8'h00,             1'b0, 1'b1, 8'h00, 1'b1},
      '{pvc_pkg::OP_TEXT,   8'hFF,             1'b1, 1'b1, 8'hFF, 1'b1},
      '{pvc_pkg::OP_APPEND, pvc_pkg::ESC_BYTE, 1'b0, 1'b0, 8'h00, 1'b0},
      '{pvc_pkg::OP_APPEND, 8'h5B,             1'b0, 1'b0, 8'h00, 1'b0},
      '{pvc_pkg::OP_APPEND, 8'h31,             1'b0, 1'b0, 8'h00, 1'b0},
      '{pvc_pkg::OP_APPEND, pvc_pkg::ESC_END,  1'b0, 1'b0, 8'h00, 1'b0},
      '{pvc_pkg::OP_TEXT,   8'h20,             1'b0, 1'b1, 8'h20, 1'b1},
      '{pvc_pkg::OP_APPEND, 8'h1F,             1'b0, 1'b0, 8'h00, 1'b0},
      '{pvc_pkg::OP_APPEND, 8'h7F,             1'b1, 1'b0, 8'h00, 1'b0},
      '{pvc_pkg::OP_APPEND, 8'h20,             1'b0, 1'b0, 8'h00, 1'b0},
      '{pvc_pkg::OP_APPEND, 8'h7E,             1'b0, 1'b0, 8'h00, 1'b0},
      '{pvc_pkg::OP_TEXT,   8'h7E,             1'b0, 1'b1, 8'h7E, 1'b0},
      '{pvc_pkg::OP_TEXT,   8'h7E,             1'b0, 1'b1, 8'h7D, 1'b0},
      '{pvc_pkg::OP_TEXT,   8'h1F,             1'b0, 1'b0, 8'h00, 1'b0},
      '{pvc_pkg::OP_TEXT,   8'h80,             1'b1, 1'b0, 8'h00, 1'b0},
      '{pvc_pkg::OP_TEXT,   8'h20,             1'b1, 1'b1, 8'h20, 1'b0},
      '{pvc_pkg::OP_TEXT,   8'h20,             1'b1, 1'b0, 8'h00, 1'b0},
      '{pvc_pkg::OP_REWIND, 8'hA5,             1'b1, 1'b0, 8'h00, 1'b0},
      '{pvc_pkg::OP_TEXT,   8'h61,             1'b1, 1'b0, 8'h00, 1'b0},
      '{pvc_pkg::OP_CLEAR,  8'h00,             1'b0, 1'b0, 8'h00, 1'b0},
      '{pvc_pkg::OP_TEXT,   8'h7F,             1'b0, 1'b1, 8'h7F, 1'b1},
      '{pvc_pkg::OP_APPEND, pvc_pkg::ESC_BYTE, 1'b0, 1'b0, 8'h00, 1'b0},
      '{pvc_pkg::OP_CLEAR,  8'hFF,             1'b1, 1'b0, 8'h00, 1'b0},
      '{pvc_pkg::OP_APPEND, 8'h6B,             1'b0, 1'b0, 8'h00, 1'b0},
      '{pvc_pkg::OP_TEXT,   8'h6B,             1'b0, 1'b0, 8'h00, 1'b0}
   };

   printable_vigenere_cipher u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Update the key state for one request and queue the byte it should produce
   task automatic cipher_apply(input pvc_pkg::opcode_type op, input logic [7:0] b,
                               input logic dec);
      int lo;
      int span;
      int bi;
      int k;
      int p;
      int r;
      lo   = int'(pvc_pkg::CODE_LOW);
      span = int'(pvc_pkg::CODE_SPAN);
      bi   = int'(b);
      case (op)
         pvc_pkg::OP_CLEAR: begin
            key_len  = 0;
            key_pos  = 0;
            esc_open = 1'b0;
         end
         pvc_pkg::OP_APPEND: begin
            if (esc_open) begin
               if (b == pvc_pkg::ESC_END) esc_open = 1'b0;
            end else if (b == pvc_pkg::ESC_BYTE) begin
               esc_open = 1'b1;
            end else if (b >= pvc_pkg::CODE_LOW && b <= pvc_pkg::CODE_HIGH &&
                         key_len < pvc_pkg::KEY_DEPTH) begin
               key_mem[key_len] = b[6:0];
               key_len++;
            end
         end
         pvc_pkg::OP_REWIND: key_pos = 0;
         default: begin
            if (key_len == 0) begin
               cipher_q.push_back('{b, 1'b1});
            end else if (b >= pvc_pkg::CODE_LOW && b <= pvc_pkg::CODE_HIGH) begin
               p = (key_pos >= key_len) ? 0 : key_pos;
               k = int'(key_mem[p]);
               if (dec) r = (bi + 2 * span - k) % span + lo;
               else     r = ((bi - lo) + (k - lo)) % span + lo;
               p++;
               key_pos = (p >= key_len) ? 0 : p;
               cipher_q.push_back('{r[7:0], 1'b0});
            end
         end
      endcase
   endtask

   task automatic send_request(input pvc_pkg::opcode_type op, input logic [7:0] b,
                               input logic dec, input bit typed, input logic [7:0] t_byte,
                               input logic t_pass);
      @(negedge clock);
      while (idle_on && $urandom_range(99) < 29) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= {dec, op};
      cur_typed  = typed;
      cur_t_byte = t_byte;
      cur_t_pass = t_pass;
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   task automatic send_plain(input pvc_pkg::opcode_type op, input logic [7:0] b,
                             input logic dec);
      send_request(op, b, dec, 1'b0, 8'h00, 1'b0);
   endtask

   always @(negedge clock) begin
      if (idle_on) rsp_tready <= ($urandom_range(99) >= 29);
      else         rsp_tready <= 1'b1;
   end

   // Check responses first, then predict for the request taken on this edge
   always @(posedge clock) begin
      int depth;
      cipher_out_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (cipher_q.size() == 0) begin
               $error("unexpected response: out_byte 0x%02h passed_through %0b",
                      rsp_tdata, rsp_tuser);
               errors++;
            end else begin
               want = cipher_q.pop_front();
               if (rsp_tdata !== want.out_byte) begin
                  $error("out_byte: expected 0x%02h, actual 0x%02h", want.out_byte, rsp_tdata);
                  errors++;
               end
               if (rsp_tuser !== want.passed) begin
                  $error("passed_through: expected %0b, actual %0b", want.passed, rsp_tuser);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            depth = cipher_q.size();
            cipher_apply(pvc_pkg::opcode_type'(req_tuser[1:0]), req_tdata, req_tuser[2]);
            if (cur_typed && cipher_q.size() > depth)
               cipher_q[$] = '{cur_t_byte, cur_t_pass};
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      int         pick;
      int         klen;
      int         c;
      bit         filled;
      logic       dec;
      filled = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (script[i])
         send_request(script[i].op, script[i].data, script[i].dec,
                      script[i].typed, script[i].t_byte, script[i].t_pass);

      while (sent < RANDOM_LEN) begin
         // Hold both sides busy through one long stretch
         idle_on = !(sent >= 900 && sent < 1200);
         pick = $urandom_range(99);
         if (pick < 10) begin
            repeat (12)
               send_plain(pvc_pkg::opcode_type'($urandom_range(3)), 8'($urandom_range(255)),
                          1'($urandom_range(1)));
         end else begin
            if ($urandom_range(3) != 0)
               send_plain(pvc_pkg::OP_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
            // First message overfills the key store
            if (!filled)                     klen = pvc_pkg::KEY_DEPTH + 64;
            else if ($urandom_range(9) == 0) klen = 0;
            else                             klen = $urandom_range(16, 1);
            filled = 1'b1;
            for (int i = 0; i < klen; i++) begin
               c = $urandom_range(19);
               if (c == 0) begin
                  send_plain(pvc_pkg::OP_APPEND, 8'($urandom_range(255)),
                             1'($urandom_range(1)));
               end else if (c == 1) begin
                  send_plain(pvc_pkg::OP_APPEND, pvc_pkg::ESC_BYTE, 1'($urandom_range(1)));
                  repeat ($urandom_range(3))
                     send_plain(pvc_pkg::OP_APPEND, 8'($urandom_range(255)),
                                1'($urandom_range(1)));
                  send_plain(pvc_pkg::OP_APPEND, pvc_pkg::ESC_END, 1'($urandom_range(1)));
               end else begin
                  send_plain(pvc_pkg::OP_APPEND, 8'($urandom_range(126, 32)),
                             1'($urandom_range(1)));
               end
            end
            dec = 1'($urandom_range(1));
            send_plain(pvc_pkg::OP_REWIND, 8'($urandom_range(255)), 1'($urandom_range(1)));
            repeat ($urandom_range(40, 8)) begin
               c = $urandom_range(29);
               if (c == 0)
                  send_plain(pvc_pkg::OP_REWIND, 8'($urandom_range(255)),
                             1'($urandom_range(1)));
               else if (c < 3)
                  send_plain(pvc_pkg::OP_TEXT, 8'($urandom_range(255)),
                             1'($urandom_range(1)));
               else
                  send_plain(pvc_pkg::OP_TEXT, 8'($urandom_range(126, 32)), dec);
            end
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      idle_on = 1'b1;
      while (cipher_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
